[rtl/jts_pkg.sv]
// Shared types, token and error codes, and word constants for the JSON token scanner.
// Used by the scanner core, the result queue and the top level; depends on nothing.
`default_nettype none

package jts_pkg;

  localparam int DEF_LINE_BITS   = 16;
  localparam int DEF_COLUMN_BITS = 16;
  localparam int POS_BITS        = 16;

  // Result queue: room for three items per input byte plus slack for one in flight.
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_RESULTS     = 3;

  localparam logic [3:0] K_LBRACE   = 4'd0;
  localparam logic [3:0] K_RBRACE   = 4'd1;
  localparam logic [3:0] K_LBRACKET = 4'd2;
  localparam logic [3:0] K_RBRACKET = 4'd3;
  localparam logic [3:0] K_COMMA    = 4'd4;
  localparam logic [3:0] K_COLON    = 4'd5;
  localparam logic [3:0] K_STRBYTE  = 4'd6;
  localparam logic [3:0] K_STREND   = 4'd7;
  localparam logic [3:0] K_NUMBYTE  = 4'd8;
  localparam logic [3:0] K_NUMEND   = 4'd9;
  localparam logic [3:0] K_NULL     = 4'd10;
  localparam logic [3:0] K_TRUE     = 4'd11;
  localparam logic [3:0] K_FALSE    = 4'd12;
  localparam logic [3:0] K_EOF      = 4'd13;
  localparam logic [3:0] K_ERROR    = 4'd14;

  localparam logic [2:0] E_NONE         = 3'd0;
  localparam logic [2:0] E_INVALID_CHAR = 3'd1;
  localparam logic [2:0] E_BAD_ESCAPE   = 3'd2;
  localparam logic [2:0] E_BAD_HEX      = 3'd3;
  localparam logic [2:0] E_BAD_LITERAL  = 3'd4;
  localparam logic [2:0] E_UNTERMINATED = 3'd5;

  localparam logic [31:0] WORD_NULL  = "null";
  localparam logic [31:0] WORD_TRUE  = "true";
  localparam logic [39:0] WORD_FALSE = "false";

  localparam logic [3:0] HEX_SHIFT [4] = '{4'd12, 4'd8, 4'd4, 4'd0};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          token_kind;
    logic [7:0]          token_byte;
    logic [POS_BITS-1:0] token_line;
    logic [POS_BITS-1:0] token_column;
    logic [2:0]          error_code;
    logic                last_result;
  } result_t;

  // Results of one accepted byte, handed from the scanner to the queue.
  typedef struct packed {
    logic [1:0]                     count;
    result_t [MAX_RESULTS-1:0]      items;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] kind;
  } word_match_t;

  // Classify a collected word; length 6 marks an overlong word.
  function automatic word_match_t match_word(input logic [4:0][7:0] buf_v,
                                             input logic [2:0] len);
    word_match_t m;
    m.hit  = 1'b0;
    m.kind = K_ERROR;
    if (len == 3'd4 && {buf_v[0], buf_v[1], buf_v[2], buf_v[3]} == WORD_NULL) begin
      m.hit  = 1'b1;
      m.kind = K_NULL;
    end else if (len == 3'd4 && {buf_v[0], buf_v[1], buf_v[2], buf_v[3]} == WORD_TRUE) begin
      m.hit  = 1'b1;
      m.kind = K_TRUE;
    end else if (len == 3'd5 &&
                 {buf_v[0], buf_v[1], buf_v[2], buf_v[3], buf_v[4]} == WORD_FALSE) begin
      m.hit  = 1'b1;
      m.kind = K_FALSE;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/jts_chan_if.sv]
// Valid/ready channel carrying one payload item per handshake.
// Payload type is set per instance, normally from jts_pkg.
`default_nettype none

interface jts_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/jts_scan_core.sv]
// Scanner state and per-byte next-state logic; yields up to three results per byte.
// Depends on jts_pkg.
`default_nettype none

module jts_scan_core import jts_pkg::*; #(
  parameter int LINE_BITS   = DEF_LINE_BITS,
  parameter int COLUMN_BITS = DEF_COLUMN_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_item_t item,
  output push_t    push
);

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_STRING = 3'd1;
  localparam logic [2:0] M_ESCAPE = 3'd2;
  localparam logic [2:0] M_HEX    = 3'd3;
  localparam logic [2:0] M_NUMBER = 3'd4;
  localparam logic [2:0] M_WORD   = 3'd5;
  localparam logic [2:0] M_HALT   = 3'd6;

  logic [2:0]             mode, mode_next;
  logic [LINE_BITS-1:0]   line_cnt, line_cnt_next;
  logic [COLUMN_BITS-1:0] col_cnt, col_cnt_next;
  logic [LINE_BITS-1:0]   start_line, start_line_next;
  logic [COLUMN_BITS-1:0] start_col, start_col_next;
  logic [4:0][7:0]        word_buf, word_buf_next;
  logic [2:0]             word_len, word_len_next;
  logic [15:0]            hex_val, hex_val_next;
  logic [1:0]             hex_cnt, hex_cnt_next;

  logic [7:0]             c;
  logic                   is_num, is_alpha, hex_ok;
  logic [3:0]             hex_digit;
  logic [15:0]            hex_sum;
  logic [LINE_BITS-1:0]   line_step;
  logic [COLUMN_BITS-1:0] col_step;
  logic                   esc_ok;
  logic [7:0]             esc_val;
  logic                   fresh;
  logic [2:0]             n;
  logic [1:0]             cnt;
  result_t                res [4];
  word_match_t            wm;

  function automatic result_t mk(input logic [3:0] kind, input logic [7:0] b,
                                 input logic [LINE_BITS-1:0] ln,
                                 input logic [COLUMN_BITS-1:0] col,
                                 input logic [2:0] err);
    result_t r;
    r.token_kind   = kind;
    r.token_byte   = b;
    r.token_line   = POS_BITS'(ln);
    r.token_column = POS_BITS'(col);
    r.error_code   = err;
    r.last_result  = 1'b0;
    return r;
  endfunction

  assign c        = item.in_byte;
  assign is_num   = (c inside {["0":"9"], "e", "E", "+", "-", "."});
  assign is_alpha = (c inside {["a":"z"], ["A":"Z"]});

  always_comb begin
    hex_ok    = 1'b1;
    hex_digit = 4'd0;
    if (c inside {["0":"9"]}) begin
      hex_digit = 4'(c - "0");
    end else if (c inside {["a":"f"]}) begin
      hex_digit = 4'(c - "a" + 8'd10);
    end else if (c inside {["A":"F"]}) begin
      hex_digit = 4'(c - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_sum = hex_val + ({12'd0, hex_digit} << HEX_SHIFT[hex_cnt]);

  always_comb begin
    esc_ok  = 1'b1;
    esc_val = c;
    case (c)
      "\\", "\"", "/": esc_val = c;
      "b":            esc_val = 8'd8;
      "f":            esc_val = 8'd12;
      "n":            esc_val = 8'd10;
      "r":            esc_val = 8'd13;
      "t":            esc_val = 8'd9;
      default:        esc_ok  = 1'b0;
    endcase
  end

  // Every byte advances the position at most once, always from the stored counters.
  always_comb begin
    if (c == 8'h0A) begin
      line_step = (&line_cnt) ? line_cnt : line_cnt + 1'b1;
      col_step  = COLUMN_BITS'(1);
    end else begin
      line_step = line_cnt;
      col_step  = (&col_cnt) ? col_cnt : col_cnt + 1'b1;
    end
  end

  always_comb begin
    mode_next       = mode;
    line_cnt_next   = line_cnt;
    col_cnt_next    = col_cnt;
    start_line_next = start_line;
    start_col_next  = start_col;
    word_buf_next   = word_buf;
    word_len_next   = word_len;
    hex_val_next    = hex_val;
    hex_cnt_next    = hex_cnt;
    fresh           = 1'b0;
    n               = 3'd0;
    wm              = match_word(word_buf, word_len);
    for (int i = 0; i < 4; i++) res[i] = '0;

    case (mode)
      M_NUMBER: begin
        if (is_num) begin
          line_cnt_next = line_step;
          col_cnt_next  = col_step;
          res[n[1:0]] = mk(K_NUMBYTE, c, start_line, start_col, E_NONE);
          n = n + 3'd1;
        end else begin
          res[n[1:0]] = mk(K_NUMEND, 8'd0, start_line, start_col, E_NONE);
          n = n + 3'd1;
          mode_next = M_IDLE;
          fresh     = 1'b1;
        end
      end
      M_WORD: begin
        if (is_alpha) begin
          line_cnt_next = line_step;
          col_cnt_next  = col_step;
          if (word_len < 3'd5) begin
            word_buf_next[word_len] = c;
            word_len_next = word_len + 3'd1;
          end else begin
            word_len_next = 3'd6;
          end
        end else if (wm.hit) begin
          res[n[1:0]] = mk(wm.kind, 8'd0, start_line, start_col, E_NONE);
          n = n + 3'd1;
          mode_next = M_IDLE;
          fresh     = 1'b1;
        end else begin
          res[n[1:0]] = mk(K_ERROR, 8'd0, start_line, start_col, E_BAD_LITERAL);
          n = n + 3'd1;
          mode_next = M_HALT;
        end
      end
      M_STRING: begin
        line_cnt_next = line_step;
        col_cnt_next  = col_step;
        if (c == "\"") begin
          res[n[1:0]] = mk(K_STREND, 8'd0, start_line, start_col, E_NONE);
          n = n + 3'd1;
          mode_next = M_IDLE;
        end else if (c == "\\") begin
          mode_next = M_ESCAPE;
        end else begin
          res[n[1:0]] = mk(K_STRBYTE, c, start_line, start_col, E_NONE);
          n = n + 3'd1;
        end
      end
      M_ESCAPE: begin
        line_cnt_next = line_step;
        col_cnt_next  = col_step;
        if (c == "u") begin
          hex_val_next = 16'd0;
          hex_cnt_next = 2'd0;
          mode_next    = M_HEX;
        end else if (esc_ok) begin
          res[n[1:0]] = mk(K_STRBYTE, esc_val, start_line, start_col, E_NONE);
          n = n + 3'd1;
          mode_next = M_STRING;
        end else begin
          res[n[1:0]] = mk(K_ERROR, 8'd0, line_step, col_step, E_BAD_ESCAPE);
          n = n + 3'd1;
          mode_next = M_HALT;
        end
      end
      M_HEX: begin
        line_cnt_next = line_step;
        col_cnt_next  = col_step;
        if (!hex_ok) begin
          res[n[1:0]] = mk(K_ERROR, 8'd0, line_step, col_step, E_BAD_HEX);
          n = n + 3'd1;
          mode_next = M_HALT;
        end else begin
          hex_val_next = hex_sum;
          if (hex_cnt == 2'd3) begin
            res[n[1:0]] = mk(K_STRBYTE, hex_sum[7:0], start_line, start_col, E_NONE);
            n = n + 3'd1;
            hex_cnt_next = 2'd0;
            mode_next    = M_STRING;
          end else begin
            hex_cnt_next = hex_cnt + 2'd1;
          end
        end
      end
      M_IDLE:  fresh = 1'b1;
      default: ;
    endcase

    // Start a new token at this byte; counters have not moved yet on this path.
    if (fresh) begin
      start_line_next = line_cnt;
      start_col_next  = col_cnt;
      line_cnt_next   = line_step;
      col_cnt_next    = col_step;
      case (c)
        "{": begin res[n[1:0]] = mk(K_LBRACE, 8'd0, line_cnt, col_cnt, E_NONE); n = n + 3'd1; end
        "}": begin res[n[1:0]] = mk(K_RBRACE, 8'd0, line_cnt, col_cnt, E_NONE); n = n + 3'd1; end
        "[": begin
          res[n[1:0]] = mk(K_LBRACKET, 8'd0, line_cnt, col_cnt, E_NONE);
          n = n + 3'd1;
        end
        "]": begin
          res[n[1:0]] = mk(K_RBRACKET, 8'd0, line_cnt, col_cnt, E_NONE);
          n = n + 3'd1;
        end
        ",": begin res[n[1:0]] = mk(K_COMMA, 8'd0, line_cnt, col_cnt, E_NONE); n = n + 3'd1; end
        ":": begin res[n[1:0]] = mk(K_COLON, 8'd0, line_cnt, col_cnt, E_NONE); n = n + 3'd1; end
        "\"": mode_next = M_STRING;
        " ", 8'h0A, 8'h0D, 8'h09: ;
        default: begin
          if (is_num) begin
            res[n[1:0]] = mk(K_NUMBYTE, c, line_cnt, col_cnt, E_NONE);
            n = n + 3'd1;
            mode_next = M_NUMBER;
          end else if (is_alpha) begin
            word_buf_next[0] = c;
            word_len_next    = 3'd1;
            mode_next        = M_WORD;
          end else begin
            res[n[1:0]] = mk(K_ERROR, 8'd0, line_cnt, col_cnt, E_INVALID_CHAR);
            n = n + 3'd1;
            mode_next = M_HALT;
          end
        end
      endcase
    end

    // Final byte: close any open token, report eof unless halted, then return to reset values.
    if (item.end_of_source) begin
      wm = match_word(word_buf_next, word_len_next);
      case (mode_next)
        M_NUMBER: begin
          res[n[1:0]] = mk(K_NUMEND, 8'd0, start_line_next, start_col_next, E_NONE);
          n = n + 3'd1;
          mode_next = M_IDLE;
        end
        M_WORD: begin
          if (wm.hit) begin
            res[n[1:0]] = mk(wm.kind, 8'd0, start_line_next, start_col_next, E_NONE);
            n = n + 3'd1;
            mode_next = M_IDLE;
          end else begin
            res[n[1:0]] = mk(K_ERROR, 8'd0, start_line_next, start_col_next, E_BAD_LITERAL);
            n = n + 3'd1;
            mode_next = M_HALT;
          end
        end
        M_STRING, M_ESCAPE, M_HEX: begin
          res[n[1:0]] = mk(K_ERROR, 8'd0, start_line_next, start_col_next, E_UNTERMINATED);
          n = n + 3'd1;
          mode_next = M_HALT;
        end
        default: ;
      endcase
      if (mode_next != M_HALT && n < 3'd4) begin
        res[n[1:0]] = mk(K_EOF, 8'd0, line_cnt_next, col_cnt_next, E_NONE);
        n = n + 3'd1;
      end
      mode_next       = M_IDLE;
      line_cnt_next   = LINE_BITS'(1);
      col_cnt_next    = COLUMN_BITS'(1);
      start_line_next = '0;
      start_col_next  = '0;
      word_buf_next   = '0;
      word_len_next   = 3'd0;
      hex_val_next    = 16'd0;
      hex_cnt_next    = 2'd0;
    end

    // At most three results leave per byte; drop any beyond that.
    cnt = (n > 3'd3) ? 2'd3 : n[1:0];
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i].last_result = (2'(i) == cnt - 2'd1);
      push.items[i]      = res[i];
    end
    push.count = take ? cnt : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      line_cnt   <= LINE_BITS'(1);
      col_cnt    <= COLUMN_BITS'(1);
      start_line <= '0;
      start_col  <= '0;
      word_buf   <= '0;
      word_len   <= 3'd0;
      hex_val    <= 16'd0;
      hex_cnt    <= 2'd0;
    end else if (take) begin
      mode       <= mode_next;
      line_cnt   <= line_cnt_next;
      col_cnt    <= col_cnt_next;
      start_line <= start_line_next;
      start_col  <= start_col_next;
      word_buf   <= word_buf_next;
      word_len   <= word_len_next;
      hex_val    <= hex_val_next;
      hex_cnt    <= hex_cnt_next;
    end
  end

endmodule

`default_nettype wire

[rtl/jts_result_queue.sv]
// Result queue: takes up to three results per cycle, delivers one per handshake.
// Depends on jts_pkg and jts_chan_if.
`default_nettype none

module jts_result_queue import jts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output logic       room,
  jts_chan_if.source out_ch
);

  result_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] fill, fill_next;
  logic                      pop;

  assign out_ch.valid   = (fill != '0);
  assign out_ch.payload = slots[rd_ptr];
  assign pop            = out_ch.valid && out_ch.ready;
  // Accept a byte only when its worst-case result count fits.
  assign room           = (fill <= QUEUE_CNT_BITS'(QUEUE_DEPTH - MAX_RESULTS));
  assign fill_next      = fill + QUEUE_CNT_BITS'(push.count) - QUEUE_CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < push.count) begin
        slots[wr_ptr + QUEUE_PTR_BITS'(i)] <= push.items[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(push.count);
      rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(pop);
      fill   <= fill_next;
    end
  end

endmodule

`default_nettype wire

[rtl/json_token_scanner_top.sv]
// JSON token scanner, top level. One source byte per input item, token results out.
// A byte's results are written into the result queue when the byte is accepted and leave it in order.
// Throughput: one byte per cycle while the 4-entry result queue has room for three
//   results; results leave one per cycle, so output handshakes set the sustained rate.
// Reset: synchronous rst returns to idle scanning at line 1, column 1, queue empty.
// Depends on jts_pkg, jts_chan_if, jts_scan_core and jts_result_queue.
`default_nettype none

module json_token_scanner_top import jts_pkg::*; #(
  parameter int LINE_BITS   = DEF_LINE_BITS,
  parameter int COLUMN_BITS = DEF_COLUMN_BITS
) (
  input  logic     clk,
  input  logic     rst,
  jts_chan_if.sink   in_ch,
  jts_chan_if.source out_ch
);

  logic     room;
  logic     take;
  in_item_t item;
  push_t    push;

  // Hold off input while the queue might not fit a full burst of three results.
  assign in_ch.ready = room;
  assign take        = in_ch.valid && room;
  assign item        = in_ch.payload;

  // Scanner: decode the byte against the current mode, advance position,
  // and produce this byte's results in the same cycle.
  jts_scan_core #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (item),
    .push (push)
  );

  // Queue: register results and drain them in order, one item per handshake.
  jts_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

[bench/tb_jts_checker.sv]
// Checker for the JSON token scanner: watches both channels, predicts token results per byte.
// Depends on jts_pkg (codes, result_t) and jts_chan_if; instantiated beside the block by tb_top.
`default_nettype none

module tb_jts_checker import jts_pkg::*; (
  input  logic clk,
  input  logic rst,
  jts_chan_if  in_ch,
  jts_chan_if  out_ch,
  output int   pending,
  output int   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_STRING, MODE_ESCAPE, MODE_HEX, MODE_NUMBER, MODE_WORD, MODE_HALT
  } scan_mode_e;

  localparam logic [7:0]  CH_TAB      = 8'h09;
  localparam logic [7:0]  CH_LF       = 8'h0A;
  localparam logic [7:0]  CH_CR       = 8'h0D;
  localparam logic [7:0]  CH_SP       = 8'h20;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam int          MAX_REPORTS = 40;

  scan_mode_e  mode;
  logic [15:0] line_pos, col_pos;
  logic [15:0] tok_line, tok_col;
  logic [7:0]  word_chars [5];
  int          word_len;
  logic [15:0] hex_acc;
  int          hex_cnt;

  result_t     byte_tokens [MAX_RESULTS];
  int          n_tokens;
  result_t     token_fifo [$];
  int          mismatches;
  int          reports;

  function automatic void reset_scanner();
    mode     = MODE_IDLE;
    line_pos = 16'd1;
    col_pos  = 16'd1;
    tok_line = '0;
    tok_col  = '0;
    foreach (word_chars[i]) word_chars[i] = 8'h00;
    word_len = 0;
    hex_acc  = '0;
    hex_cnt  = 0;
  endfunction

  function automatic void advance_position(input logic [7:0] c);
    if (c == CH_LF) begin
      if (line_pos != POS_MAX) line_pos++;
      col_pos = 16'd1;
    end else if (col_pos != POS_MAX) begin
      col_pos++;
    end
  endfunction

  function automatic bit is_number_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "e" || c == "E" || c == "+" || c == "-" || c == ".";
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Drop anything past the third token of one byte, as the block does.
  function automatic void queue_token(input logic [3:0] kind, input logic [7:0] b,
                                      input logic [15:0] ln, input logic [15:0] col,
                                      input logic [2:0] err);
    result_t r;
    if (n_tokens >= MAX_RESULTS) return;
    r.token_kind   = kind;
    r.token_byte   = b;
    r.token_line   = ln;
    r.token_column = col;
    r.error_code   = err;
    r.last_result  = 1'b0;
    byte_tokens[n_tokens] = r;
    n_tokens++;
  endfunction

  function automatic void abort_scan(input logic [2:0] err, input logic [15:0] ln,
                                     input logic [15:0] col);
    queue_token(K_ERROR, 8'h00, ln, col, err);
    mode = MODE_HALT;
  endfunction

  function automatic void close_word();
    logic [31:0] four;
    logic [39:0] five;
    four = {word_chars[0], word_chars[1], word_chars[2], word_chars[3]};
    five = {four, word_chars[4]};
    if (word_len == 4 && four == "null") begin
      queue_token(K_NULL, 8'h00, tok_line, tok_col, E_NONE);
    end else if (word_len == 4 && four == "true") begin
      queue_token(K_TRUE, 8'h00, tok_line, tok_col, E_NONE);
    end else if (word_len == 5 && five == "false") begin
      queue_token(K_FALSE, 8'h00, tok_line, tok_col, E_NONE);
    end else begin
      abort_scan(E_BAD_LITERAL, tok_line, tok_col);
      return;
    end
    mode = MODE_IDLE;
  endfunction

  function automatic void start_token(input logic [7:0] c);
    tok_line = line_pos;
    tok_col  = col_pos;
    advance_position(c);
    case (c)
      "{":  queue_token(K_LBRACE, 8'h00, tok_line, tok_col, E_NONE);
      "}":  queue_token(K_RBRACE, 8'h00, tok_line, tok_col, E_NONE);
      "[":  queue_token(K_LBRACKET, 8'h00, tok_line, tok_col, E_NONE);
      "]":  queue_token(K_RBRACKET, 8'h00, tok_line, tok_col, E_NONE);
      ",":  queue_token(K_COMMA, 8'h00, tok_line, tok_col, E_NONE);
      ":":  queue_token(K_COLON, 8'h00, tok_line, tok_col, E_NONE);
      "\"": mode = MODE_STRING;
      CH_SP, CH_LF, CH_CR, CH_TAB: ;
      default: begin
        if (is_number_char(c)) begin
          queue_token(K_NUMBYTE, c, tok_line, tok_col, E_NONE);
          mode = MODE_NUMBER;
        end else if (is_letter(c)) begin
          word_chars[0] = c;
          word_len      = 1;
          mode          = MODE_WORD;
        end else begin
          abort_scan(E_INVALID_CHAR, tok_line, tok_col);
        end
      end
    endcase
  endfunction

  function automatic void scan_byte(input logic [7:0] c);
    logic [7:0] decoded;
    logic [7:0] digit;
    bit         known;
    decoded = 8'h00;
    digit   = 8'h00;
    case (mode)
      MODE_IDLE: start_token(c);
      MODE_NUMBER: begin
        if (is_number_char(c)) begin
          advance_position(c);
          queue_token(K_NUMBYTE, c, tok_line, tok_col, E_NONE);
        end else begin
          // the terminating byte starts a token of its own
          queue_token(K_NUMEND, 8'h00, tok_line, tok_col, E_NONE);
          mode = MODE_IDLE;
          start_token(c);
        end
      end
      MODE_WORD: begin
        if (is_letter(c)) begin
          advance_position(c);
          if (word_len < 5) begin
            word_chars[word_len] = c;
            word_len++;
          end else begin
            word_len = 6;
          end
        end else begin
          close_word();
          if (mode == MODE_IDLE) start_token(c);
        end
      end
      MODE_STRING: begin
        advance_position(c);
        if (c == "\"") begin
          queue_token(K_STREND, 8'h00, tok_line, tok_col, E_NONE);
          mode = MODE_IDLE;
        end else if (c == "\\") begin
          mode = MODE_ESCAPE;
        end else begin
          queue_token(K_STRBYTE, c, tok_line, tok_col, E_NONE);
        end
      end
      MODE_ESCAPE: begin
        advance_position(c);
        known = 1'b1;
        case (c)
          "\\", "\"", "/": decoded = c;
          "b":     decoded = 8'h08;
          "f":     decoded = 8'h0C;
          "n":     decoded = CH_LF;
          "r":     decoded = CH_CR;
          "t":     decoded = CH_TAB;
          default: known = 1'b0;
        endcase
        if (c == "u") begin
          hex_acc = '0;
          hex_cnt = 0;
          mode    = MODE_HEX;
        end else if (!known) begin
          abort_scan(E_BAD_ESCAPE, line_pos, col_pos);
        end else begin
          queue_token(K_STRBYTE, decoded, tok_line, tok_col, E_NONE);
          mode = MODE_STRING;
        end
      end
      MODE_HEX: begin
        advance_position(c);
        known = 1'b1;
        if (c >= "0" && c <= "9") digit = c - "0";
        else if (c >= "a" && c <= "f") digit = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F") digit = c - "A" + 8'd10;
        else known = 1'b0;
        if (!known) begin
          abort_scan(E_BAD_HEX, line_pos, col_pos);
        end else begin
          // most significant digit first; only the low byte survives
          hex_acc = hex_acc + (16'(digit) << (12 - 4 * hex_cnt));
          if (hex_cnt >= 3) begin
            queue_token(K_STRBYTE, hex_acc[7:0], tok_line, tok_col, E_NONE);
            hex_cnt = 0;
            mode    = MODE_STRING;
          end else begin
            hex_cnt++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_byte(input logic [7:0] c, input logic eos);
    n_tokens = 0;
    if (mode != MODE_HALT) scan_byte(c);
    if (eos) begin
      if (mode == MODE_NUMBER) begin
        queue_token(K_NUMEND, 8'h00, tok_line, tok_col, E_NONE);
        mode = MODE_IDLE;
      end else if (mode == MODE_WORD) begin
        close_word();
      end else if (mode == MODE_STRING || mode == MODE_ESCAPE || mode == MODE_HEX) begin
        abort_scan(E_UNTERMINATED, tok_line, tok_col);
      end
      if (mode != MODE_HALT) queue_token(K_EOF, 8'h00, line_pos, col_pos, E_NONE);
      reset_scanner();
    end
    if (n_tokens > 0) byte_tokens[n_tokens-1].last_result = 1'b1;
    for (int i = 0; i < n_tokens; i++) token_fifo.push_back(byte_tokens[i]);
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (reports < MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      reports++;
    end
  endfunction

  function automatic void check_token(input result_t got);
    result_t want;
    if (token_fifo.size() == 0) begin
      mismatches++;
      if (reports < MAX_REPORTS)
        $display("%0t: token expected none actual kind %0d", $time, got.token_kind);
      reports++;
      return;
    end
    want = token_fifo.pop_front();
    compare_field("token_kind", 16'(want.token_kind), 16'(got.token_kind));
    compare_field("token_byte", 16'(want.token_byte), 16'(got.token_byte));
    compare_field("token_line", want.token_line, got.token_line);
    compare_field("token_column", want.token_column, got.token_column);
    compare_field("error_code", 16'(want.error_code), 16'(got.error_code));
    compare_field("last_result", 16'(want.last_result), 16'(got.last_result));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_scanner();
      token_fifo.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_byte(in_ch.payload.in_byte, in_ch.payload.end_of_source);
      if (out_ch.valid && out_ch.ready)
        check_token(out_ch.payload);
    end
    pending    <= token_fifo.size();
    fail_count <= mismatches;
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Top of the JSON token scanner bench: clock, reset, byte stimulus and the receiver side.
// Depends on jts_pkg, jts_chan_if, json_token_scanner_top and tb_jts_checker.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jts_pkg::*;

  localparam int RANDOM_ITEMS  = 430;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 1500000;

  // Idle percentages per phase: none, sender only, receiver only, both.
  localparam int SRC_IDLE  [4] = '{0, 85, 0, 27};
  localparam int SNK_STALL [4] = '{0, 0, 85, 27};

  localparam logic [7:0] PUNCT   [6] = '{"{", "}", "[", "]", ",", ":"};
  localparam logic [7:0] WHITE   [4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
  localparam logic [7:0] ESCAPES [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};

  logic clk;
  logic rst;

  jts_chan_if #(.payload_t(in_item_t)) in_ch ();
  jts_chan_if #(.payload_t(result_t))  out_ch ();

  int         pending;
  int         fail_count;
  int         src_idle_pct;
  int         snk_stall_pct;
  int         hold_asks;
  int         items_sent;
  int         cycle_count;
  logic [7:0] doc_bytes [$];

  json_token_scanner_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tb_jts_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Receiver: stall at random, or hold ready low for a long stretch when asked.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Watchdog: end the run as failed once the cycle limit is reached.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // Offer one byte, idling first at the current rate, and hold it until accepted.
  // Keep valid high between back-to-back items so it is never dropped and raised in one step.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= {b, eos};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Send a whole source text; the last byte carries the end flag.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc_bytes.size(); i++) send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
  endtask

  // Drop valid and wait until every predicted token has come back, then let the block settle.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_hex_char();
    int d;
    d = $urandom_range(15);
    if (d < 10) return "0" + 8'(d);
    return ($urandom_range(1) ? "a" : "A") + 8'(d - 10);
  endfunction

  function automatic logic [7:0] pick_number_char();
    int r;
    r = $urandom_range(16);
    case (r)
      10:      return "e";
      11:      return "E";
      12:      return "+";
      13:      return "-";
      14:      return ".";
      default: return "0" + 8'(r % 10);
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    return ($urandom_range(1) ? "a" : "A") + 8'($urandom_range(25));
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
  endfunction

  // String content: plain text, raw control and high bytes, short escapes and \u sequences.
  function automatic void add_string_body(input int n);
    logic [7:0] c;
    repeat (n) begin
      case ($urandom_range(7))
        0, 1, 2: begin
          c = 8'($urandom_range(126, 32));
          if (c == "\"" || c == "\\") c = "_";
          doc_bytes.push_back(c);
        end
        3: doc_bytes.push_back($urandom_range(1) ? 8'($urandom_range(255, 128))
                                                 : 8'($urandom_range(31)));
        4, 5: begin
          doc_bytes.push_back("\\");
          doc_bytes.push_back(ESCAPES[$urandom_range(7)]);
        end
        default: begin
          push_text("\\u");
          repeat (4) doc_bytes.push_back(pick_hex_char());
        end
      endcase
    end
  endfunction

  // Broken strings: a bad escape, a bad hex digit, or a source that ends inside the string.
  function automatic void add_broken_string(input int flaw);
    logic [7:0] c;
    doc_bytes.push_back("\"");
    add_string_body($urandom_range(2));
    case (flaw)
      0: begin
        c = 8'($urandom_range(255));
        while (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" || c == "n" ||
               c == "r" || c == "t" || c == "u")
          c = 8'($urandom_range(255));
        doc_bytes.push_back("\\");
        doc_bytes.push_back(c);
      end
      1: begin
        c = 8'($urandom_range(255));
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
          c = 8'($urandom_range(255));
        push_text("\\u");
        repeat ($urandom_range(3)) doc_bytes.push_back(pick_hex_char());
        doc_bytes.push_back(c);
      end
      2: begin
        // end inside an escape or inside a \u sequence
        doc_bytes.push_back("\\");
        if ($urandom_range(1)) begin
          doc_bytes.push_back("u");
          repeat ($urandom_range(3)) doc_bytes.push_back(pick_hex_char());
        end
      end
      default: ;
    endcase
    // bytes after an error are swallowed up to the end flag
    if (flaw < 2) repeat ($urandom_range(3)) doc_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Mostly well-formed token soup with random content; a few broken or pure-noise texts.
  function automatic void build_doc();
    int flaw;
    int w;
    flaw = $urandom_range(19);
    doc_bytes.delete();
    if (flaw == 19) begin
      repeat ($urandom_range(6, 1)) doc_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(10, 1)) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4: doc_bytes.push_back(PUNCT[$urandom_range(5)]);
        5:             doc_bytes.push_back(WHITE[$urandom_range(3)]);
        6, 7, 8, 9: begin
          doc_bytes.push_back("\"");
          add_string_body($urandom_range(4));
          doc_bytes.push_back("\"");
        end
        10, 11, 12: begin
          repeat ($urandom_range(4, 1)) doc_bytes.push_back(pick_number_char());
          if ($urandom_range(3) != 0) doc_bytes.push_back(PUNCT[$urandom_range(5)]);
        end
        13, 14, 15, 16: begin
          w = $urandom_range(9);
          if (w < 3) push_text("null");
          else if (w < 6) push_text("true");
          else if (w < 8) push_text("false");
          else repeat ($urandom_range(7, 1)) doc_bytes.push_back(pick_letter());
          if ($urandom_range(3) != 0) doc_bytes.push_back(PUNCT[$urandom_range(5)]);
          else doc_bytes.push_back(WHITE[$urandom_range(3)]);
        end
        default: begin
          // stray byte, often a harmless blank
          if ($urandom_range(2) == 0) doc_bytes.push_back(8'($urandom_range(255)));
          else doc_bytes.push_back(8'h20);
        end
      endcase
    end
    if (flaw < 4) add_broken_string(flaw);
  endfunction

  initial begin : stimulus
    int base;
    rst           = 1'b1;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_asks     = 0;
    items_sent    = 0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: all punctuation, \u with mixed-case hex, literals, a number closed by
    // the end flag, a zero byte, a bad escape on the final byte, and an error followed
    // by an ignored byte.
    send_text("{\"\\u0aF9\":[true]}");
    send_text("null,7");
    send_byte(8'h00, 1'b1);
    send_text("\"\\x");
    send_byte(8'hFF, 1'b0);
    send_byte("]", 1'b1);
    wait_for_drain();

    base = items_sent;
    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = SRC_IDLE[p];
      snk_stall_pct <= SNK_STALL[p];
      // Hold the receiver off while bytes keep coming, so the queue fills and input stalls.
      if (p == 0) hold_asks <= hold_asks + 1;
      while (items_sent < base + (p + 1) * RANDOM_ITEMS / 4) begin
        build_doc();
        send_doc();
      end
      wait_for_drain();
    end

    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
